[design/disk_controller_registers_top_defines.svh]
// Assertion macros shared by the disk controller register block.
`ifndef DISK_CONTROLLER_REGISTERS_TOP_DEFINES_SVH
`define DISK_CONTROLLER_REGISTERS_TOP_DEFINES_SVH

// Check a same-cycle implication on the rising edge of clk, outside reset.
`define DCR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcr check failed: same-cycle implication");

// Check an implication whose consequent holds in the next cycle.
`define DCR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcr check failed: next-cycle implication");

`endif

[design/dcr_pkg.sv]
// Types, constants and register map of the disk controller register block.
`default_nettype none

package dcr_pkg;

  // Geometry defaults
  localparam int WORDS_PER_SECTOR_DEF  = 256;
  localparam int SECTORS_PER_TRACK_DEF = 12;
  localparam int LAST_CYLINDER_DEF     = 202;

  // Item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Register addresses
  localparam logic [17:0] ADDR_DS = 18'o777400;
  localparam logic [17:0] ADDR_ER = 18'o777402;
  localparam logic [17:0] ADDR_CS = 18'o777404;
  localparam logic [17:0] ADDR_WC = 18'o777406;
  localparam logic [17:0] ADDR_BA = 18'o777410;
  localparam logic [17:0] ADDR_DA = 18'o777412;

  // Function codes in CS bits 3:1
  localparam logic [2:0] FUNC_CTRL_RESET  = 3'd0;
  localparam logic [2:0] FUNC_WRITE       = 3'd1;
  localparam logic [2:0] FUNC_READ        = 3'd2;
  localparam logic [2:0] FUNC_SEEK        = 3'd4;
  localparam logic [2:0] FUNC_DRIVE_RESET = 3'd6;

  // Register bits
  localparam int CS_GO  = 0;
  localparam int CS_IE  = 6;
  localparam int CS_RDY = 7;
  localparam int CS_SCP = 13;
  localparam int DS_RDY = 6;
  localparam int ER_NXD = 7;
  localparam int ER_OVR = 14;

  // Reset values and masks
  localparam logic [15:0] DS_RESET   = 16'o4700;
  localparam logic [15:0] CS_RESET   = 16'o200;
  localparam logic [15:0] CS_RO_MASK = 16'hf080;
  localparam logic [15:0] CS_RD_MASK = 16'hfffe;

  typedef struct packed {
    logic [1:0]  kind;
    logic [17:0] bus_address;
    logic [15:0] write_data;
  } dcr_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        bus_error;
    logic        irq;
    logic        xfer_valid;
    logic        xfer_write;
    logic [17:0] xfer_bus_addr;
    logic [12:0] xfer_block;
    logic [8:0]  xfer_words;
    logic [7:0]  zero_fill;
  } dcr_out_t;

  // Controller state; drive select lives in DA bits 15:13
  typedef struct packed {
    logic        ds_ready;
    logic [15:0] er;
    logic [15:0] cs;
    logic [15:0] wc;
    logic [15:0] ba;
    logic [15:0] da;
    logic [7:0]  cyl;
    logic        head;
    logic [3:0]  sect;
  } dcr_state_t;

  localparam dcr_state_t STATE_RESET = '{
    ds_ready: DS_RESET[DS_RDY],
    er:       16'h0,
    cs:       CS_RESET,
    wc:       16'h0,
    ba:       16'h0,
    da:       16'h0,
    cyl:      8'h0,
    head:     1'b0,
    sect:     4'h0
  };

endpackage

`default_nettype wire

[design/dcr_exec.sv]
// Register access and command step logic: next state and result of one item.
`default_nettype none

module dcr_exec import dcr_pkg::*; #(
  parameter int WORDS_PER_SECTOR  = WORDS_PER_SECTOR_DEF,
  parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF,
  parameter int LAST_CYLINDER     = LAST_CYLINDER_DEF
) (
  input  dcr_state_t st,
  input  dcr_in_t    item,
  output dcr_state_t st_nxt,
  output dcr_out_t   res
);

  localparam logic [16:0] WPS17 = 17'(WORDS_PER_SECTOR);
  localparam logic [8:0]  WPS9  = 9'(WORDS_PER_SECTOR);
  localparam logic [4:0]  SPT5  = 5'(SECTORS_PER_TRACK);
  localparam logic [8:0]  LAST9 = 9'(LAST_CYLINDER);

  logic [2:0]  func;
  logic [15:0] neg_wc;
  logic [8:0]  words;
  logic [16:0] ba_sum;
  logic [13:0] track_base;
  logic [13:0] block_sum;
  logic [4:0]  sect_inc;
  logic        sect_wrap;
  logic [8:0]  cyl_inc;
  logic        cyl_ovf;
  logic [15:0] ds_word;

  assign func = st.cs[3:1];

  // Words this sector: the smaller of the remaining count and a full sector
  assign neg_wc = 16'(~st.wc) + 16'd1;
  assign words  = ({1'b0, neg_wc} < WPS17) ? neg_wc[8:0] : WPS9;
  assign ba_sum = {1'b0, st.ba} + {7'd0, words, 1'b0};

  // Disk block from cylinder, surface and sector
  assign track_base = 14'({st.cyl, st.head}) * 14'(SPT5);
  assign block_sum  = track_base + {10'd0, st.sect};

  // Position advance
  assign sect_inc  = {1'b0, st.sect} + 5'd1;
  assign sect_wrap = (sect_inc >= SPT5);
  assign cyl_inc   = {1'b0, st.cyl} + 9'd1;
  assign cyl_ovf   = (cyl_inc > LAST9);

  always_comb begin
    ds_word = DS_RESET;
    ds_word[DS_RDY] = st.ds_ready;
  end

  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (item.kind)
      KIND_READ: begin
        unique case (item.bus_address)
          ADDR_DS: res.read_data = ds_word;
          ADDR_ER: res.read_data = st.er;
          ADDR_CS: res.read_data = st.cs & CS_RD_MASK;
          ADDR_WC: res.read_data = st.wc;
          ADDR_DA: res.read_data = st.da;
          default: res.bus_error = 1'b1;
        endcase
      end
      KIND_WRITE: begin
        unique case (item.bus_address)
          ADDR_CS: st_nxt.cs = (item.write_data & ~CS_RO_MASK) | (st.cs & CS_RO_MASK);
          ADDR_WC: st_nxt.wc = item.write_data;
          ADDR_BA: st_nxt.ba = item.write_data;
          ADDR_DA: begin
            st_nxt.da   = item.write_data;
            st_nxt.cyl  = item.write_data[12:5];
            st_nxt.head = item.write_data[4];
            st_nxt.sect = item.write_data[3:0];
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (st.cs[CS_GO]) begin
          unique case (func)
            FUNC_CTRL_RESET: st_nxt = STATE_RESET;
            FUNC_WRITE, FUNC_READ: begin
              st_nxt.ds_ready   = 1'b0;
              st_nxt.cs[CS_RDY] = 1'b0;
              if (st.wc == 16'd0) begin
                // Nothing left: finish the command
                st_nxt.ds_ready   = 1'b1;
                st_nxt.cs[CS_RDY] = 1'b1;
                st_nxt.cs[CS_GO]  = 1'b0;
                res.irq           = st.cs[CS_IE];
              end else begin
                // Issue the sector descriptor
                res.xfer_valid    = 1'b1;
                res.xfer_write    = (func == FUNC_WRITE);
                res.xfer_bus_addr = {st.cs[5:4], st.ba};
                res.xfer_block    = block_sum[12:0];
                res.xfer_words    = words;
                if (func == FUNC_WRITE) begin
                  res.zero_fill = 8'(WPS9 - words);
                end
                // Advance bus address with extension carry, and word count
                if (ba_sum[16]) begin
                  st_nxt.cs[5:4] = st.cs[5:4] + 2'd1;
                end
                st_nxt.ba = ba_sum[15:0];
                st_nxt.wc = st.wc + {7'd0, words};
                // Advance sector, surface and cylinder
                if (sect_wrap) begin
                  st_nxt.sect = 4'd0;
                  st_nxt.head = ~st.head;
                  if (st.head) begin
                    st_nxt.cyl = cyl_inc[7:0];
                    if (cyl_ovf) begin
                      st_nxt.er[ER_OVR] = 1'b1;
                      st_nxt.ds_ready   = 1'b1;
                      st_nxt.cs[CS_RDY] = 1'b1;
                      st_nxt.cs[CS_GO]  = 1'b0;
                      res.irq           = st.cs[CS_IE];
                    end
                  end
                end else begin
                  st_nxt.sect = sect_inc[3:0];
                end
              end
            end
            FUNC_SEEK, FUNC_DRIVE_RESET: begin
              if (func == FUNC_DRIVE_RESET) begin
                st_nxt.er = 16'h0;
              end
              st_nxt.ds_ready   = 1'b0;
              st_nxt.cs[CS_RDY] = 1'b0;
              st_nxt.cs[CS_GO]  = 1'b0;
              if (st.da[15:13] != 3'd0) begin
                // Only drive zero exists
                st_nxt.er[ER_NXD] = 1'b1;
                res.irq           = 1'b1;
              end else begin
                st_nxt.cs[CS_SCP] = 1'b0;
                st_nxt.cs[CS_RDY] = 1'b1;
                res.irq           = st.cs[CS_IE];
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/disk_controller_registers_top.sv]
// Top level of the disk controller register block: input, state and result registers.
//
//   port group   direction   handshake            payload
//   in_*         into block  in_valid / in_stall  dcr_in_t  (kind, bus_address, write_data)
//   out_*        out of blk  out_valid/ out_stall dcr_out_t (read_data ... zero_fill)
//
// One item per cycle while out_stall is low; an item moves from input to result register.
// All work for an item is one pass of dcr_exec between the input and result registers.
// Synchronous active-low reset returns the controller registers to their power-on values.
// A stalled result holds the result register; the input register then fills and in_stall rises.
`default_nettype none
`include "disk_controller_registers_top_defines.svh"

module disk_controller_registers_top import dcr_pkg::*; #(
  parameter int WORDS_PER_SECTOR  = WORDS_PER_SECTOR_DEF,
  parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF,
  parameter int LAST_CYLINDER     = LAST_CYLINDER_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dcr_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output dcr_out_t out_item
);

  logic       in_valid_r, in_valid_nxt;
  dcr_in_t    in_item_r;
  logic       out_valid_r, out_valid_nxt;
  dcr_out_t   out_item_r;
  dcr_state_t state_r, state_nxt;
  dcr_out_t   result_nxt;
  logic       advance;
  logic       in_take;

  // Move the held item into the result register when that register frees up
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  dcr_exec #(
    .WORDS_PER_SECTOR  (WORDS_PER_SECTOR),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .LAST_CYLINDER     (LAST_CYLINDER)
  ) u_exec (
    .st     (state_r),
    .item   (in_item_r),
    .st_nxt (state_nxt),
    .res    (result_nxt)
  );

  // Valid flags for both stages
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A drained result with nothing behind it leaves the output empty
  `DCR_ASSERT_NXT(a_out_drain, out_valid_r && !out_stall && !advance, !out_valid_r)
  // Descriptors and interrupts come only from ticks
  `DCR_ASSERT_IMP(a_tick_only, advance && in_item_r.kind != KIND_TICK,
                  !result_nxt.xfer_valid && !result_nxt.irq)
  // Bus errors come only from reads
  `DCR_ASSERT_IMP(a_berr_read, advance && result_nxt.bus_error, in_item_r.kind == KIND_READ)
  // An interrupt always ends the command
  `DCR_ASSERT_NXT(a_irq_ends, advance && result_nxt.irq, !state_r.cs[CS_GO])
  // After a descriptor, either the command runs on busy or it ended ready
  `DCR_ASSERT_NXT(a_xfer_ctl, advance && result_nxt.xfer_valid,
                  state_r.cs[CS_GO] != state_r.cs[CS_RDY])

endmodule

`default_nettype wire

[tb/tb_disk_controller_registers_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the disk controller register block: table-driven and random items.
module tb_disk_controller_registers_top;
  import dcr_pkg::*;

  localparam int WPS = WORDS_PER_SECTOR_DEF;
  localparam int SPT = SECTORS_PER_TRACK_DEF;
  localparam int LAST_CYL = LAST_CYLINDER_DEF;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [2:0] FUNC_WRITE_CHECK = 3'd3;
  localparam logic [2:0] FUNC_READ_CHECK  = 3'd5;
  localparam logic [2:0] FUNC_WRITE_LOCK  = 3'd7;

  localparam int ITEMS_PER_PHASE = 440;
  localparam int DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 250000;

  localparam int SEND_IDLE [4]  = '{0, 56, 0, 38};
  localparam int RECV_STALL [4] = '{0, 0, 56, 38};

  localparam logic [17:0] REG_ADDRS [6] = '{ADDR_DS, ADDR_ER, ADDR_CS, ADDR_WC, ADDR_BA, ADDR_DA};

  typedef struct packed {
    logic [1:0]  kind;
    logic [17:0] addr;
    logic [15:0] data;
    logic        typed;
    logic [15:0] want_rd;
    logic        want_err;
  } dir_row_t;

  typedef struct packed {
    dcr_in_t  item;
    logic     typed;
    dcr_out_t want;
  } feed_t;

  // Directed items: reset values, unmapped reads, a one-sector write that crosses
  // the address carry and the last cylinder, a read of the rest, seek on a missing drive
  localparam dir_row_t DIRECTED [25] = '{
    '{KIND_READ,  ADDR_DS,     16'h0000, 1'b1, 16'o4700, 1'b0},
    '{KIND_READ,  ADDR_ER,     16'h0000, 1'b1, 16'h0000, 1'b0},
    '{KIND_READ,  ADDR_CS,     16'h0000, 1'b1, 16'o0200, 1'b0},
    '{KIND_READ,  ADDR_WC,     16'h0000, 1'b1, 16'h0000, 1'b0},
    '{KIND_READ,  ADDR_DA,     16'h0000, 1'b1, 16'h0000, 1'b0},
    '{KIND_READ,  ADDR_BA,     16'h0000, 1'b1, 16'h0000, 1'b1},
    '{KIND_NONE,  18'h3ffff,   16'hffff, 1'b1, 16'h0000, 1'b0},
    '{KIND_TICK,  18'h00000,   16'h0000, 1'b1, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_WC,     16'hfed4, 1'b0, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_BA,     16'hff00, 1'b0, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_DA,     16'h195b, 1'b0, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_CS,     16'hffff, 1'b0, 16'h0000, 1'b0},
    '{KIND_TICK,  18'h3ffff,   16'hffff, 1'b1, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_CS,     16'h0f73, 1'b0, 16'h0000, 1'b0},
    '{KIND_TICK,  18'h00000,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{KIND_READ,  ADDR_ER,     16'h0000, 1'b0, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_CS,     16'h0005, 1'b0, 16'h0000, 1'b0},
    '{KIND_TICK,  18'h00000,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{KIND_TICK,  18'h00000,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_DA,     16'hffff, 1'b0, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_CS,     16'h0049, 1'b0, 16'h0000, 1'b0},
    '{KIND_TICK,  18'h00000,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{KIND_WRITE, ADDR_CS,     16'h0001, 1'b0, 16'h0000, 1'b0},
    '{KIND_TICK,  18'h00000,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{KIND_READ,  ADDR_DS,     16'h0000, 1'b1, 16'o4700, 1'b0}
  };

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  dcr_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  dcr_out_t out_item;

  feed_t    feed_q [$];
  dcr_out_t result_q [$];
  feed_t    cur_row;
  dcr_out_t want_res;
  int       err_cnt = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int unsigned cycle_cnt = 0;

  // Controller state as predicted
  logic [15:0] ds_r, er_r, cs_r, wc_r, ba_r, da_r;
  logic [2:0]  drv_r;
  logic [7:0]  cyl_r;
  logic        head_r;
  logic [3:0]  sect_r;

  disk_controller_registers_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_state();
    ds_r = DS_RESET;
    er_r = 16'h0;
    cs_r = CS_RESET;
    wc_r = 16'h0;
    ba_r = 16'h0;
    da_r = 16'h0;
    drv_r = 3'd0;
    cyl_r = 8'd0;
    head_r = 1'b0;
    sect_r = 4'd0;
  endfunction

  function automatic void clear_ready();
    ds_r[DS_RDY] = 1'b0;
    cs_r[CS_RDY] = 1'b0;
  endfunction

  // End the command: ready and done up, GO down
  function automatic void end_command();
    ds_r[DS_RDY] = 1'b1;
    cs_r[CS_RDY] = 1'b1;
    cs_r[CS_GO] = 1'b0;
  endfunction

  // Issue one sector descriptor, then advance address, count and position; end the command when the count is zero
  function automatic void move_sector(inout dcr_out_t r);
    int   remain, words, sum, s, h, c;
    logic is_wr;
    is_wr = (cs_r[3:1] == FUNC_WRITE);
    clear_ready();
    if (wc_r == 16'h0) begin
      end_command();
      r.irq = cs_r[CS_IE];
      return;
    end
    remain = 65536 - int'(wc_r);
    words = (remain < WPS) ? remain : WPS;
    r.xfer_valid = 1'b1;
    r.xfer_write = is_wr;
    r.xfer_bus_addr = {cs_r[5:4], ba_r};
    r.xfer_block = 13'((int'(cyl_r) * 2 + int'(head_r)) * SPT + int'(sect_r));
    r.xfer_words = 9'(words);
    r.zero_fill = is_wr ? 8'(WPS - words) : 8'h0;
    sum = int'(ba_r) + 2 * words;
    if (sum > 65535) cs_r[5:4] = cs_r[5:4] + 2'd1;
    ba_r = 16'(sum);
    wc_r = 16'(int'(wc_r) + words);
    s = int'(sect_r) + 1;
    h = int'(head_r);
    c = int'(cyl_r);
    if (s >= SPT) begin
      s = 0;
      h++;
      if (h > 1) begin
        h = 0;
        c++;
        // past the last cylinder: flag overrun and stop
        if (c > LAST_CYL) begin
          er_r[ER_OVR] = 1'b1;
          end_command();
          r.irq = cs_r[CS_IE];
        end
      end
    end
    sect_r = 4'(s);
    head_r = h[0];
    cyl_r = 8'(c);
  endfunction

  function automatic void run_function(inout dcr_out_t r);
    case (cs_r[3:1])
      FUNC_CTRL_RESET: reset_state();
      FUNC_WRITE, FUNC_READ: move_sector(r);
      FUNC_SEEK, FUNC_DRIVE_RESET: begin
        if (cs_r[3:1] == FUNC_DRIVE_RESET) er_r = 16'h0;
        clear_ready();
        if (drv_r != 3'd0) begin
          er_r[ER_NXD] = 1'b1;
          cs_r[CS_GO] = 1'b0;
          r.irq = 1'b1;
        end else begin
          cs_r[CS_SCP] = 1'b0;
          cs_r[CS_RDY] = 1'b1;
          cs_r[CS_GO] = 1'b0;
          r.irq = cs_r[CS_IE];
        end
      end
      default: ;
    endcase
  endfunction

  // Work out the result of one item and update the predicted registers
  function automatic dcr_out_t controller_step(dcr_in_t it);
    dcr_out_t r;
    logic [15:0] v;
    r = '0;
    v = it.write_data;
    case (it.kind)
      KIND_READ: begin
        case (it.bus_address)
          ADDR_DS: r.read_data = ds_r;
          ADDR_ER: r.read_data = er_r;
          ADDR_CS: r.read_data = cs_r & CS_RD_MASK;
          ADDR_WC: r.read_data = wc_r;
          ADDR_DA: r.read_data = da_r;
          default: r.bus_error = 1'b1;
        endcase
      end
      KIND_WRITE: begin
        case (it.bus_address)
          ADDR_CS: cs_r = (v & ~CS_RO_MASK) | (cs_r & CS_RO_MASK);
          ADDR_WC: wc_r = v;
          ADDR_BA: ba_r = v;
          ADDR_DA: begin
            da_r = v;
            drv_r = v[15:13];
            cyl_r = v[12:5];
            head_r = v[4];
            sect_r = v[3:0];
          end
          default: ;
        endcase
      end
      KIND_TICK: if (cs_r[CS_GO]) run_function(r);
      default: ;
    endcase
    return r;
  endfunction

  // Queue one item; returns 1 when the block acts on it
  function automatic int push_item(logic [1:0] k, logic [17:0] a, logic [15:0] d);
    feed_t f;
    f.item.kind = k;
    f.item.bus_address = a;
    f.item.write_data = d;
    f.typed = 1'b0;
    f.want = '0;
    feed_q.push_back(f);
    if (k == KIND_NONE) return 0;
    if (k == KIND_WRITE && !(a inside {ADDR_CS, ADDR_WC, ADDR_BA, ADDR_DA})) return 0;
    return 1;
  endfunction

  // Queue a short burst of arbitrary items
  function automatic int add_noise();
    int cnt, n, roll;
    logic [17:0] a;
    cnt = 0;
    n = $urandom_range(1, 4);
    repeat (n) begin
      roll = $urandom_range(9);
      if (roll < 7) a = REG_ADDRS[$urandom_range(5)];
      else if (roll == 7) a = REG_ADDRS[$urandom_range(5)] ^ 18'($urandom_range(1, 7));
      else a = 18'($urandom);
      cnt += push_item(2'($urandom_range(3)), a, 16'($urandom));
    end
    return cnt;
  endfunction

  // Queue a command program: set up WC, BA, DA, start with CS, then tick it along
  function automatic int add_program();
    int cnt, roll, n;
    logic [15:0] wc, ba, da, cs;
    logic [2:0]  fn;
    cnt = 0;
    roll = $urandom_range(9);
    if (roll == 0) wc = 16'h0;
    else if (roll == 1) wc = 16'($urandom);
    else wc = 16'(0 - $urandom_range(1, 1300));
    ba = ($urandom_range(2) == 0) ? 16'(16'hffff - $urandom_range(1023)) : 16'($urandom);
    da = 16'($urandom);
    if ($urandom_range(7) != 0) da[15:13] = 3'd0;
    if ($urandom_range(3) == 0) da[12:5] = 8'($urandom_range(198, 255));
    roll = $urandom_range(19);
    if (roll < 6) fn = FUNC_WRITE;
    else if (roll < 12) fn = FUNC_READ;
    else if (roll < 14) fn = FUNC_SEEK;
    else if (roll < 16) fn = FUNC_DRIVE_RESET;
    else if (roll == 16) fn = FUNC_CTRL_RESET;
    else if (roll == 17) fn = FUNC_WRITE_CHECK;
    else if (roll == 18) fn = FUNC_READ_CHECK;
    else fn = FUNC_WRITE_LOCK;
    cs = 16'($urandom);
    cs[3:1] = fn;
    cs[CS_GO] = ($urandom_range(9) != 0);
    // skip some setup writes so state carries over from the last command
    if ($urandom_range(4) != 0) cnt += push_item(KIND_WRITE, ADDR_WC, wc);
    if ($urandom_range(4) != 0) cnt += push_item(KIND_WRITE, ADDR_BA, ba);
    if ($urandom_range(4) != 0) cnt += push_item(KIND_WRITE, ADDR_DA, da);
    cnt += push_item(KIND_WRITE, ADDR_CS, cs);
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(3) == 0)
        cnt += push_item(KIND_READ, REG_ADDRS[$urandom_range(5)], 16'($urandom));
      cnt += push_item(KIND_TICK, 18'($urandom), 16'($urandom));
    end
    return cnt;
  endfunction

  function automatic void check_field(string name, logic [17:0] want, logic [17:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Hold until every queued item is sent and every result has arrived
  task automatic wait_quiet();
    do @(negedge clk);
    while (feed_q.size() != 0 || in_valid || result_q.size() != 0);
  endtask

  // Predict each accepted transfer, then present the next item at the falling edge
  initial begin : feeder
    logic     took;
    dcr_out_t predicted;
    forever begin
      @(posedge clk);
      took = rst_n && in_valid && !in_stall;
      if (took) begin
        predicted = controller_step(cur_row.item);
        result_q.push_back(cur_row.typed ? cur_row.want : predicted);
      end
      @(negedge clk);
      if (!in_valid || took) begin
        if (rst_n && feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_row = feed_q.pop_front();
          in_item <= cur_row.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result with no prediction pending: %h", out_item);
        err_cnt++;
      end else begin
        want_res = result_q.pop_front();
        check_field("read_data", want_res.read_data, out_item.read_data);
        check_field("bus_error", want_res.bus_error, out_item.bus_error);
        check_field("irq", want_res.irq, out_item.irq);
        check_field("xfer_valid", want_res.xfer_valid, out_item.xfer_valid);
        check_field("xfer_write", want_res.xfer_write, out_item.xfer_write);
        check_field("xfer_bus_addr", want_res.xfer_bus_addr, out_item.xfer_bus_addr);
        check_field("xfer_block", want_res.xfer_block, out_item.xfer_block);
        check_field("xfer_words", want_res.xfer_words, out_item.xfer_words);
        check_field("zero_fill", want_res.zero_fill, out_item.zero_fill);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
    end
  end

  initial begin : sequencer
    int    made;
    feed_t f;
    reset_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // walk the directed table
    foreach (DIRECTED[i]) begin
      f.item.kind = DIRECTED[i].kind;
      f.item.bus_address = DIRECTED[i].addr;
      f.item.write_data = DIRECTED[i].data;
      f.typed = DIRECTED[i].typed;
      f.want = '0;
      f.want.read_data = DIRECTED[i].want_rd;
      f.want.bus_error = DIRECTED[i].want_err;
      feed_q.push_back(f);
    end
    // random programs and noise under each idling mix, draining between mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      made = 0;
      while (made < ITEMS_PER_PHASE) begin
        if ($urandom_range(4) == 0) made += add_noise();
        else made += add_program();
      end
      wait_quiet();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
